>>> hdl/streaming_int8_average_pool_core_defines.svh
// Assertion macros shared by the average pool RTL.
`ifndef STREAMING_INT8_AVERAGE_POOL_CORE_DEFINES_SVH
`define STREAMING_INT8_AVERAGE_POOL_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIAP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/siap_pkg.sv
// Shared types, constants and helpers of the average pool block.
`default_nettype none

package siap_pkg;

  // Field widths of the configuration and the item ports
  localparam int POOL_W     = 4;
  localparam int CHANNELS_W = 6;
  localparam int DIM_W      = 8;
  localparam int SAMPLE_W   = 8;
  localparam int ROW_W      = 7;
  localparam int COL_W      = 7;
  localparam int CHAN_W     = 5;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  // Output clamp bounds
  localparam int AVG_MIN = -128;
  localparam int AVG_MAX = 127;

  // Register reset values
  localparam logic [POOL_W-1:0]     POOL_RST       = 4'd2;
  localparam logic [CHANNELS_W-1:0] CHANNELS_RST   = 6'd1;
  localparam logic [DIM_W-1:0]      IN_WIDTH_RST   = 8'd28;
  localparam logic [DIM_W-1:0]      OUT_WIDTH_RST  = 8'd14;
  localparam logic [DIM_W-1:0]      OUT_HEIGHT_RST = 8'd14;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_POOL_SIZE  = 3'd0,
    REG_CHANNELS   = 3'd1,
    REG_IN_WIDTH   = 3'd2,
    REG_OUT_WIDTH  = 3'd3,
    REG_OUT_HEIGHT = 3'd4
  } reg_index_t;

  // Raw register contents
  typedef struct packed {
    logic [POOL_W-1:0]     pool_size;
    logic [CHANNELS_W-1:0] channels;
    logic [DIM_W-1:0]      in_width;
    logic [DIM_W-1:0]      out_width;
    logic [DIM_W-1:0]      out_height;
  } cfg_t;

  // One classified sample handed from the front to the back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic [CHAN_W-1:0]          chan;
    logic                       first;      // opens its window
    logic                       last_win;   // closes its window
    logic                       frame_end;  // last result of the frame
  } work_t;

  // Pool side in use: zero acts as one, large values saturate
  function automatic logic [4:0] eff_pool(input logic [POOL_W-1:0] ps, input int max_pool);
    logic [4:0] k;
    if (ps == '0) begin
      k = 5'd1;
    end else if (int'(ps) > max_pool) begin
      k = 5'(max_pool);
    end else begin
      k = 5'(ps);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

>>> hdl/siap_queue.sv
// Small FIFO between the classifying front and the accumulating back.
`default_nettype none

module siap_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

`include "streaming_int8_average_pool_core_defines.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `SIAP_ASSERT_NOW(a_no_overflow, clk, rst, push, !full, "queue written while full")
  `SIAP_ASSERT_NOW(a_no_underflow, clk, rst, pop, !empty, "queue read while empty")
  `SIAP_ASSERT_NEXT(a_fill_up, clk, rst, push && !pop, count == $past(count) + CNT_W'(1), "queue fill level did not grow on a lone write")

endmodule

`default_nettype wire

>>> hdl/siap_front.sv
// Front end: position counters, window classification and sum address.
`default_nettype none

module siap_front import siap_pkg::*; #(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_CHANNELS = 32,
  parameter int MAX_POOL     = 8,
  localparam int IDX_W       = $clog2(MAX_WIDTH * MAX_CHANNELS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       pool_wr,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       frame_start,
  output logic                       q_push,
  output work_t                      q_work,
  output logic [IDX_W-1:0]           q_idx,
  input  logic                       q_full
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCW   = $clog2(MAX_CHANNELS + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int KW    = $clog2(MAX_POOL + 1);
  localparam int PW    = $clog2(MAX_POOL);
  localparam int AW    = $clog2(MAX_WIDTH + 2 * MAX_POOL + 1);
  localparam int PRODW = CW + NCW;

  // counters
  logic [CHW-1:0] chan_pos, chan_pos_next;
  logic [CW-1:0]  col_pos, col_pos_next;
  logic [WW-1:0]  row_pos, row_pos_next;
  logic [PW-1:0]  row_phase, row_phase_next;
  logic [CW-1:0]  col_phase, col_phase_next;  // wider than the pool during resync
  logic [CW-1:0]  col_win, col_win_next;      // output column of col_pos
  logic           resync, resync_next;

  // effective configuration
  logic [KW-1:0]  k;
  logic [NCW-1:0] nc;
  logic [WW-1:0]  w;
  logic [WW-1:0]  ow;
  logic [WW-1:0]  oh;

  // counters as seen by the current sample
  logic [CHW-1:0] c_chan;
  logic [CW-1:0]  c_col;
  logic [WW-1:0]  c_row;
  logic [PW-1:0]  c_rph;
  logic [CW-1:0]  c_cph;
  logic [CW-1:0]  c_ox;

  logic [AW-1:0]    win_base;
  logic [AW-1:0]    win_end;
  logic [AW-1:0]    cph_inc;
  logic [NCW-1:0]   ch_inc;
  logic [WW-1:0]    col_inc;
  logic [KW-1:0]    rph_inc;
  logic [PRODW-1:0] base_prod;
  logic             contrib;
  logic             acc;

  // clamp the registers to the supported ranges
  always_comb begin
    k = KW'(eff_pool(cfg.pool_size, MAX_POOL));
    if (cfg.channels == '0) begin
      nc = NCW'(1);
    end else if (int'(cfg.channels) > MAX_CHANNELS) begin
      nc = NCW'(MAX_CHANNELS);
    end else begin
      nc = NCW'(cfg.channels);
    end
    if (cfg.in_width == '0) begin
      w = WW'(1);
    end else if (int'(cfg.in_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg.in_width);
    end
    ow = (int'(cfg.out_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg.out_width);
    oh = (int'(cfg.out_height) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg.out_height);
  end

  // frame start clears the position before this sample
  assign c_chan = frame_start ? '0 : chan_pos;
  assign c_col  = frame_start ? '0 : col_pos;
  assign c_row  = frame_start ? '0 : row_pos;
  assign c_rph  = frame_start ? '0 : row_phase;
  assign c_cph  = frame_start ? '0 : col_phase;
  assign c_ox   = frame_start ? '0 : col_win;

  assign win_base = AW'(c_col) - AW'(c_cph);
  assign win_end  = win_base + AW'(k);
  assign cph_inc  = AW'(c_cph) + AW'(1);
  assign ch_inc   = NCW'(c_chan) + NCW'(1);
  assign col_inc  = WW'(c_col) + WW'(1);
  assign rph_inc  = KW'(c_rph) + KW'(1);

  // a sample counts only inside a full window of the output grid
  assign contrib = (NCW'(c_chan) < nc) && (WW'(c_col) < w) && (c_row < oh) &&
                   (KW'(c_rph) < k) && (WW'(c_ox) < ow) && (win_end <= AW'(w));

  assign full   = resync || q_full;
  assign acc    = push && !full;
  assign q_push = acc && contrib;

  // sum address: output column times channels plus channel
  assign base_prod = PRODW'(c_ox) * PRODW'(nc);
  assign q_idx     = IDX_W'(base_prod) + IDX_W'(c_chan);

  always_comb begin
    q_work.sample    = sample;
    q_work.row       = ROW_W'(c_row);
    q_work.col       = COL_W'(c_ox);
    q_work.chan      = CHAN_W'(c_chan);
    q_work.first     = (c_cph == '0) && (c_rph == '0);
    q_work.last_win  = (cph_inc == AW'(k)) && (rph_inc == k);
    q_work.frame_end = ((c_row + WW'(1)) == oh) && (ch_inc == nc) &&
                       (((WW'(c_ox) + WW'(1)) == ow) || ((win_end + AW'(k)) > AW'(w)));
  end

  // counter advance, and resync of the column split after a pool size write
  always_comb begin
    chan_pos_next  = chan_pos;
    col_pos_next   = col_pos;
    row_pos_next   = row_pos;
    row_phase_next = row_phase;
    col_phase_next = col_phase;
    col_win_next   = col_win;
    resync_next    = resync;
    priority if (pool_wr) begin
      resync_next    = 1'b1;
      col_win_next   = '0;
      col_phase_next = col_pos;
    end else if (resync) begin
      if (AW'(col_phase) >= AW'(k)) begin
        col_phase_next = col_phase - CW'(k);
        col_win_next   = col_win + CW'(1);
      end else begin
        resync_next = 1'b0;
      end
    end else if (acc) begin
      chan_pos_next  = c_chan;
      col_pos_next   = c_col;
      row_pos_next   = c_row;
      row_phase_next = c_rph;
      col_phase_next = c_cph;
      col_win_next   = c_ox;
      if (ch_inc >= nc) begin
        chan_pos_next = '0;
        if (col_inc >= w) begin
          col_pos_next   = '0;
          col_phase_next = '0;
          col_win_next   = '0;
          if (rph_inc >= k) begin
            row_phase_next = '0;
            if (c_row < oh) begin
              row_pos_next = c_row + WW'(1);
            end
          end else begin
            row_phase_next = PW'(rph_inc);
          end
        end else begin
          col_pos_next = CW'(col_inc);
          if (cph_inc >= AW'(k)) begin
            col_phase_next = '0;
            col_win_next   = c_ox + CW'(1);
          end else begin
            col_phase_next = CW'(cph_inc);
          end
        end
      end else begin
        chan_pos_next = CHW'(ch_inc);
      end
    end
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_pos  <= '0;
      col_pos   <= '0;
      row_pos   <= '0;
      row_phase <= '0;
      col_phase <= '0;
      col_win   <= '0;
      resync    <= 1'b0;
    end else begin
      chan_pos  <= chan_pos_next;
      col_pos   <= col_pos_next;
      row_pos   <= row_pos_next;
      row_phase <= row_phase_next;
      col_phase <= col_phase_next;
      col_win   <= col_win_next;
      resync    <= resync_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/siap_back.sv
// Back end: window sum read-modify-write, rounding divider, result register.
`default_nettype none

module siap_back import siap_pkg::*; #(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_CHANNELS = 32,
  parameter int MAX_POOL     = 8,
  localparam int IDX_W       = $clog2(MAX_WIDTH * MAX_CHANNELS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  work_t                      q_work,
  input  logic [IDX_W-1:0]           q_idx,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] average,
  output logic [ROW_W-1:0]           out_row,
  output logic [COL_W-1:0]           out_col,
  output logic [CHAN_W-1:0]          out_channel,
  output logic                       last_of_frame
);

`include "streaming_int8_average_pool_core_defines.svh"

  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int SUM_W = $clog2(128 * MAX_POOL * MAX_POOL) + 2;
  localparam int NW    = SUM_W + 1;
  localparam int KW    = $clog2(MAX_POOL + 1);
  localparam int DVW   = 2 * KW;
  localparam int CNTW  = $clog2(NW);

  typedef enum logic [1:0] {B_IDLE, B_ACC, B_DIV, B_HOLD} state_t;

  state_t                    state;
  work_t                     cur;
  logic [IDX_W-1:0]          cur_idx;
  logic signed [SUM_W-1:0]   sums [DEPTH];
  logic signed [SUM_W-1:0]   rd_data;
  logic signed [SUM_W-1:0]   acc_sum;
  logic signed [NW-1:0]      sum_ext;
  logic [NW-1:0]             mag;
  logic [NW-1:0]             num;
  logic [KW-1:0]             k;
  logic [DVW-1:0]            k_sq;
  logic                      div_neg;
  logic [DVW-1:0]            div_rem;
  logic [NW-1:0]             div_quo;
  logic [CNTW-1:0]           div_cnt;
  logic [DVW:0]              trial;
  logic                      trial_ge;
  logic [DVW-1:0]            rem_next;
  logic signed [SAMPLE_W-1:0] avg_final;
  logic                      res_valid;

  assign k     = KW'(eff_pool(cfg.pool_size, MAX_POOL));
  assign k_sq  = DVW'(k) * DVW'(k);
  assign q_pop = (state == B_IDLE) && !q_empty;
  assign empty = !res_valid;

  // window sum update: first sample of a window overwrites
  assign acc_sum = cur.first ? SUM_W'(cur.sample) : rd_data + SUM_W'(cur.sample);
  assign sum_ext = NW'(acc_sum);
  assign mag     = sum_ext[NW-1] ? NW'(-sum_ext) : NW'(sum_ext);
  assign num     = mag + NW'(k_sq >> 1);

  // window sums, read at the queue head, written back from the accumulate step
  always_ff @(posedge clk) begin
    if (state == B_ACC) begin
      sums[cur_idx] <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= sums[q_idx];
  end

  // one restoring division step per cycle in the divide state
  assign trial    = {div_rem, div_quo[NW-1]};
  assign trial_ge = (trial >= {1'b0, k_sq});
  assign rem_next = trial_ge ? DVW'(trial - {1'b0, k_sq}) : DVW'(trial);

  // sign and clamp of the rounded quotient
  always_comb begin
    if (div_neg) begin
      avg_final = (div_quo > NW'(-AVG_MIN)) ? SAMPLE_W'(AVG_MIN) :
                  SAMPLE_W'(0) - SAMPLE_W'(div_quo);
    end else begin
      avg_final = (div_quo > NW'(AVG_MAX)) ? SAMPLE_W'(AVG_MAX) : SAMPLE_W'(div_quo);
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
    end else begin
      // result register fills from the hold step, empties on a result transaction
      if (state == B_HOLD && (!res_valid || pop)) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cur     <= q_work;
            cur_idx <= q_idx;
            state   <= B_ACC;
          end
        end
        B_ACC: begin
          if (cur.last_win) begin
            div_neg <= sum_ext[NW-1];
            div_rem <= '0;
            div_quo <= num;
            div_cnt <= '0;
            state   <= B_DIV;
          end else begin
            state <= B_IDLE;
          end
        end
        B_DIV: begin
          div_rem <= rem_next;
          div_quo <= {div_quo[NW-2:0], trial_ge};
          div_cnt <= div_cnt + CNTW'(1);
          if (div_cnt == CNTW'(NW - 1)) begin
            state <= B_HOLD;
          end
        end
        B_HOLD: begin
          if (!res_valid || pop) begin
            average       <= avg_final;
            out_row       <= cur.row;
            out_col       <= cur.col;
            out_channel   <= cur.chan;
            last_of_frame <= cur.frame_end;
            state         <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `SIAP_ASSERT_NEXT(a_pop_to_acc, clk, rst, q_pop, state == B_ACC, "pop without accumulate")
  `SIAP_ASSERT_NEXT(a_divides, clk, rst, state == B_ACC && cur.last_win, state == B_DIV, "no div")
  `SIAP_ASSERT_NEXT(a_hold, clk, rst, res_valid && !pop, res_valid && $stable(average), "result lost")

endmodule

`default_nettype wire

>>> hdl/streaming_int8_average_pool_core.sv
// Top level of the streaming int8 average pool: config registers and wiring.
//
//  channel   direction  transaction when                     payload
//  input     in         push && !full                        sample, frame_start
//  result    out        pop && !empty                        average, out_row, out_col,
//                                                            out_channel, last_of_frame
//  config    in/out     psel && penable && pwrite && pready  paddr, pwdata, prdata
//
// The front takes one sample per cycle while its 4-entry queue has room and no
// column resync runs; samples outside the output grid are dropped there. The back
// takes each counted sample through an idle and an accumulate step; one that closes
// a window then runs a 16-step (at MAX_POOL = 8) bit-serial divider by the squared
// pool size and a hold step that loads the result, so the back sets the sustained
// rate. A pool_size write stalls input while the column split is recomputed. Reset
// clears the counters and queue; the window sums get no clearing pass. A stalled
// result holds in the output register while the back goes on with the next samples.
`default_nettype none

module streaming_int8_average_pool_core import siap_pkg::*; #(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_CHANNELS = 32,
  parameter int MAX_POOL     = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       frame_start,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] average,
  output logic [ROW_W-1:0]           out_row,
  output logic [COL_W-1:0]           out_col,
  output logic [CHAN_W-1:0]          out_channel,
  output logic                       last_of_frame,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int IDX_W       = $clog2(MAX_WIDTH * MAX_CHANNELS);
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_W         = $bits(work_t) + IDX_W;

  cfg_t             cfg;
  reg_index_t       reg_sel;
  logic             cfg_wr;
  logic             pool_wr;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  work_t            f_work;
  work_t            b_work;
  logic [IDX_W-1:0] f_idx;
  logic [IDX_W-1:0] b_idx;
  logic [Q_W-1:0]   q_rdata;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pool_wr = cfg_wr && (reg_sel == REG_POOL_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_size  <= POOL_RST;
      cfg.channels   <= CHANNELS_RST;
      cfg.in_width   <= IN_WIDTH_RST;
      cfg.out_width  <= OUT_WIDTH_RST;
      cfg.out_height <= OUT_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_POOL_SIZE:  cfg.pool_size  <= pwdata[POOL_W-1:0];
        REG_CHANNELS:   cfg.channels   <= pwdata[CHANNELS_W-1:0];
        REG_IN_WIDTH:   cfg.in_width   <= pwdata[DIM_W-1:0];
        REG_OUT_WIDTH:  cfg.out_width  <= pwdata[DIM_W-1:0];
        REG_OUT_HEIGHT: cfg.out_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_POOL_SIZE:  prdata = DATA_W'(cfg.pool_size);
      REG_CHANNELS:   prdata = DATA_W'(cfg.channels);
      REG_IN_WIDTH:   prdata = DATA_W'(cfg.in_width);
      REG_OUT_WIDTH:  prdata = DATA_W'(cfg.out_width);
      REG_OUT_HEIGHT: prdata = DATA_W'(cfg.out_height);
      default:        prdata = '0;
    endcase
  end

  siap_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_POOL     (MAX_POOL)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pool_wr     (pool_wr),
    .push        (push),
    .full        (full),
    .sample      (sample),
    .frame_start (frame_start),
    .q_push      (q_push),
    .q_work      (f_work),
    .q_idx       (f_idx),
    .q_full      (q_full)
  );

  siap_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_work, f_idx}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_work = work_t'(q_rdata[Q_W-1:IDX_W]);
  assign b_idx  = q_rdata[IDX_W-1:0];

  siap_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_POOL     (MAX_POOL)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_work        (b_work),
    .q_idx         (b_idx),
    .empty         (empty),
    .pop           (pop),
    .average       (average),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_channel   (out_channel),
    .last_of_frame (last_of_frame)
  );

endmodule

`default_nettype wire

>>> tb/tb_streaming_int8_average_pool_core.sv
// Self-checking testbench of the streaming int8 average pool core.
import siap_pkg::*;

// One result transaction as it appears on the output ports
typedef struct packed {
  logic signed [SAMPLE_W-1:0] average;
  logic [ROW_W-1:0]           row;
  logic [COL_W-1:0]           col;
  logic [CHAN_W-1:0]          chan;
  logic                       last;
} pool_result_t;

// Predicts window averages from accepted samples and checks the results
class avg_pool_scoreboard;
  localparam int MAX_WIDTH    = 128;
  localparam int MAX_CHANNELS = 32;
  localparam int MAX_POOL     = 8;

  cfg_t         regs;
  int unsigned  chan_pos, col_pos, row_pos, row_phase;
  int           window_sums [MAX_WIDTH*MAX_CHANNELS];
  pool_result_t pending_avgs [$];
  int           errors;

  function new();
    regs.pool_size  = POOL_RST;
    regs.channels   = CHANNELS_RST;
    regs.in_width   = IN_WIDTH_RST;
    regs.out_width  = OUT_WIDTH_RST;
    regs.out_height = OUT_HEIGHT_RST;
    chan_pos = 0;
    col_pos = 0;
    row_pos = 0;
    row_phase = 0;
    errors = 0;
  endfunction

  static function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function void write_reg(reg_index_t idx, logic [DATA_W-1:0] v);
    case (idx)
      REG_POOL_SIZE:  regs.pool_size  = v[POOL_W-1:0];
      REG_CHANNELS:   regs.channels   = v[CHANNELS_W-1:0];
      REG_IN_WIDTH:   regs.in_width   = v[DIM_W-1:0];
      REG_OUT_WIDTH:  regs.out_width  = v[DIM_W-1:0];
      REG_OUT_HEIGHT: regs.out_height = v[DIM_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [DATA_W-1:0] read_reg(reg_index_t idx);
    case (idx)
      REG_POOL_SIZE:  return DATA_W'(regs.pool_size);
      REG_CHANNELS:   return DATA_W'(regs.channels);
      REG_IN_WIDTH:   return DATA_W'(regs.in_width);
      REG_OUT_WIDTH:  return DATA_W'(regs.out_width);
      REG_OUT_HEIGHT: return DATA_W'(regs.out_height);
      default:        return '0;
    endcase
  endfunction

  task report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Advance the position counters by one accepted sample; queue a result
  // when the sample closes a window inside the output grid
  function void note_sample(logic signed [SAMPLE_W-1:0] s, logic fs);
    int unsigned  k, nc, w, ow, oh, ox, cph, idx;
    int           cnt, a;
    pool_result_t r;
    k  = clip(regs.pool_size, 1, MAX_POOL);
    nc = clip(regs.channels, 1, MAX_CHANNELS);
    w  = clip(regs.in_width, 1, MAX_WIDTH);
    ow = clip(regs.out_width, 0, MAX_WIDTH);
    oh = clip(regs.out_height, 0, MAX_WIDTH);
    if (ow > w / k) ow = w / k;

    if (fs) begin
      chan_pos = 0;
      col_pos = 0;
      row_pos = 0;
      row_phase = 0;
    end

    if (chan_pos < nc && col_pos < w && row_pos < oh && row_phase < k) begin
      ox  = col_pos / k;
      cph = col_pos % k;
      if (ox < ow) begin
        idx = ox * nc + chan_pos;
        // first sample of a window opens its sum
        if (cph == 0 && row_phase == 0) window_sums[idx] = s;
        else window_sums[idx] += s;
        if (cph == k - 1 && row_phase == k - 1) begin
          a   = window_sums[idx];
          cnt = k * k;
          // round half away from zero, truncating division
          a = (a > 0) ? (a + cnt / 2) / cnt : (a - cnt / 2) / cnt;
          if (a < AVG_MIN) a = AVG_MIN;
          if (a > AVG_MAX) a = AVG_MAX;
          r.average = a[SAMPLE_W-1:0];
          r.row     = row_pos[ROW_W-1:0];
          r.col     = ox[COL_W-1:0];
          r.chan    = chan_pos[CHAN_W-1:0];
          r.last    = (row_pos == oh - 1 && ox == ow - 1 && chan_pos == nc - 1);
          pending_avgs.push_back(r);
        end
      end
    end

    // channel fastest, then column, then row
    chan_pos++;
    if (chan_pos >= nc) begin
      chan_pos = 0;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_phase++;
        if (row_phase >= k) begin
          row_phase = 0;
          if (row_pos < oh) row_pos++;
        end
      end
    end
  endfunction

  task check_avg(pool_result_t got);
    pool_result_t want;
    if (pending_avgs.size() == 0) begin
      report_mismatch($sformatf("result with none pending: avg %0d row %0d col %0d ch %0d",
                                got.average, got.row, got.col, got.chan));
      return;
    end
    want = pending_avgs.pop_front();
    if (got.average !== want.average)
      report_mismatch($sformatf("average row %0d col %0d ch %0d: got %0d want %0d",
                                want.row, want.col, want.chan, got.average, want.average));
    if (got.row !== want.row)
      report_mismatch($sformatf("out_row: got %0d want %0d", got.row, want.row));
    if (got.col !== want.col)
      report_mismatch($sformatf("out_col: got %0d want %0d", got.col, want.col));
    if (got.chan !== want.chan)
      report_mismatch($sformatf("out_channel: got %0d want %0d", got.chan, want.chan));
    if (got.last !== want.last)
      report_mismatch($sformatf("last_of_frame row %0d col %0d ch %0d: got %0b want %0b",
                                want.row, want.col, want.chan, got.last, want.last));
  endtask
endclass

module tb_streaming_int8_average_pool_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 64;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int N_DIRECTED   = 27;

  logic                       clk;
  logic                       rst         = 1'b1;
  logic                       push        = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] sample      = '0;
  logic                       frame_start = 1'b0;
  logic                       empty;
  logic                       pop         = 1'b0;
  logic signed [SAMPLE_W-1:0] average;
  logic [ROW_W-1:0]           out_row;
  logic [COL_W-1:0]           out_col;
  logic [CHAN_W-1:0]          out_channel;
  logic                       last_of_frame;
  logic                       psel        = 1'b0;
  logic                       penable     = 1'b0;
  logic                       pwrite      = 1'b0;
  logic [ADDR_W-1:0]          paddr       = '0;
  logic [DATA_W-1:0]          pwdata      = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  avg_pool_scoreboard sb;
  pool_result_t       seen_avg;
  int                 push_gap_pct  = 0;
  int                 pop_stall_pct = 0;
  int                 phase_no      = 0;

  // Directed frames on a 2x2 pool, 3 pixels wide, one output: full scale,
  // negative full scale, rounding up of a half, overrun past the frame,
  // and a frame restarted in the middle (negative half rounds away)
  int directed_items [N_DIRECTED][2] = '{
    '{127, 1}, '{127, 0}, '{5, 0}, '{127, 0}, '{127, 0}, '{-7, 0},
    '{-128, 1}, '{-128, 0}, '{99, 0}, '{-128, 0}, '{-128, 0}, '{-1, 0},
    '{1, 1}, '{1, 0}, '{-100, 0}, '{0, 0}, '{0, 0}, '{50, 0},
    '{127, 0}, '{-128, 0},
    '{60, 1}, '{60, 0}, '{-1, 1}, '{-1, 0}, '{33, 0}, '{0, 0}, '{0, 0}
  };

  streaming_int8_average_pool_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: check each result transaction, stall pop at random
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      seen_avg = '{average, out_row, out_col, out_channel, last_of_frame};
      sb.check_avg(seen_avg);
    end
    pop <= !rst && ($urandom_range(99) >= pop_stall_pct);
  end

  // Idle pattern of a phase
  task automatic set_idle(input int m);
    case (m % 4)
      0: begin push_gap_pct = 0;  pop_stall_pct = 0;  end
      1: begin push_gap_pct = 51; pop_stall_pct = 0;  end
      2: begin push_gap_pct = 0;  pop_stall_pct = 51; end
      default: begin push_gap_pct = 37; pop_stall_pct = 37; end
    endcase
  endtask

  // One input transaction; push stays high for a following sample
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic fs);
    push <= 1'b1;
    sample <= s;
    frame_start <= fs;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_sample(s, fs);
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < push_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending_avgs.size() != 0) @(posedge clk);
  endtask

  // Drain, then let samples that close no window clear the back end
  task automatic wait_drained();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write or read-back of one register
  task automatic apb_xfer(input reg_index_t idx, input bit wr, input logic [DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) sb.write_reg(idx, v);
    else if (prdata !== sb.read_reg(idx))
      sb.report_mismatch($sformatf("register %0d read back %0h want %0h",
                                   int'(idx), prdata, sb.read_reg(idx)));
  endtask

  task automatic write_config(input int k, input int nc, input int iw, input int ow,
                              input int oh);
    logic [DATA_W-1:0] vals [5];
    vals = '{DATA_W'(k), DATA_W'(nc), DATA_W'(iw), DATA_W'(ow), DATA_W'(oh)};
    for (int i = 0; i < $size(vals); i++) apb_xfer(reg_index_t'(i), 1'b1, vals[i]);
    for (int i = 0; i < $size(vals); i++) apb_xfer(reg_index_t'(i), 1'b0, '0);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Full scale values come up often so window sums reach their extremes
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return SAMPLE_W'(AVG_MIN);
      1: return SAMPLE_W'(AVG_MAX);
      default: return SAMPLE_W'($urandom_range(255));
    endcase
  endfunction

  // Random samples of a frame; noisy streams restart the frame at random
  task automatic stream(input int n, input bit fresh, input bit noisy);
    logic fs;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && n >= 16) hold_until_drained();
      sender_gap();
      fs = (i == 0) ? fresh : (noisy && $urandom_range(99) < 3);
      send_sample(rand_sample(), fs);
    end
  endtask

  task automatic run_phase(input int k, input int nc, input int iw, input int ow,
                           input int oh, input int n, input bit fresh, input bit noisy);
    wait_drained();
    write_config(k, nc, iw, ow, oh);
    set_idle(phase_no);
    phase_no++;
    stream(n, fresh, noisy);
  endtask

  // Stimulus
  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: 2x2 pool, 28 pixels wide, one channel
    set_idle(0);
    stream(30, 1'b1, 1'b1);

    wait_drained();
    write_config(2, 1, 3, 1, 1);
    for (int i = 0; i < N_DIRECTED; i++)
      send_sample(SAMPLE_W'(directed_items[i][0]), directed_items[i][1][0]);

    run_phase(2, 3, 5, 2, 2, 30, 1'b1, 1'b1);
    run_phase(1, 32, 2, 2, 1, 64, 1'b1, 1'b0);    // result on every sample
    run_phase(15, 1, 8, 255, 1, 64, 1'b1, 1'b0);  // pool above max acts as the largest
    run_phase(0, 0, 0, 5, 3, 8, 1'b1, 1'b0);      // zero fields act as one
    run_phase(1, 63, 1, 1, 1, 32, 1'b1, 1'b0);    // channels saturate
    run_phase(1, 1, 255, 200, 1, 130, 1'b1, 1'b0); // width saturates, overrun
    run_phase(2, 2, 4, 0, 2, 8, 1'b1, 1'b0);      // no output columns
    run_phase(1, 1, 4, 4, 0, 4, 1'b1, 1'b0);      // no output rows

    // one band of rows, then new settings from the next band on
    run_phase(2, 2, 4, 2, 3, 16, 1'b1, 1'b0);
    run_phase(3, 1, 7, 2, 3, 21, 1'b0, 1'b0);
    run_phase(3, 1, 7, 2, 1, 8, 1'b0, 1'b0);      // row already past the height

    wait_drained();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results pending", sb.pending_avgs.size());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
